### design/rlt_pkg.sv
// shared types, codes and constants for the refcounted length table
// no dependencies; imported by every module of the block
`default_nettype none

package rlt_pkg;

   localparam int DEF_BUCKET_COUNT    = 256;
   localparam int DEF_WAYS_PER_BUCKET = 4;
   localparam int STORE_DEPTH         = 1024;

   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 10;
   localparam int LENGTH_W = 64;
   localparam int COUNT_W  = 32;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_ACQUIRE = 3'd0,
      OP_RELEASE = 3'd1,
      OP_GET     = 3'd2,
      OP_SET     = 3'd3,
      OP_UPDATE  = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_NO_HANDLE = 3'd2,
      ST_NO_KEY    = 3'd3,
      ST_SATURATED = 3'd4
   } status_type;

   // one way of a bucket row
   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    key;
      logic [COUNT_W-1:0]  count;
      logic [LENGTH_W-1:0] length;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // captured request
   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
      logic [LENGTH_W-1:0] length;
   } cmd_type;

   // result of one operation
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [LENGTH_W-1:0] length;
      logic [COUNT_W-1:0]  count;
      status_type          status;
   } result_type;

endpackage

`default_nettype wire

### design/rlt_store.sv
// bucket row memory: one write port, one read port with registered data
// uses rlt_pkg for its parameter defaults
`default_nettype none

module rlt_store
   import rlt_pkg::*;
#(
   parameter int ROWS     = DEF_BUCKET_COUNT,
   parameter int ADDR_W   = 8,
   parameter int ROW_BITS = ENTRY_W * DEF_WAYS_PER_BUCKET
) (
   input  wire logic                clock,
   input  wire logic                rd_en,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output      logic [ROW_BITS-1:0] rd_data,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire logic [ROW_BITS-1:0] wr_data
);

   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/rlt_keymod.sv
// bucket index of a key: key mod bucket count
// mask for a power-of-two count, else registered reciprocal multiply; uses rlt_pkg
`default_nettype none

module rlt_keymod
   import rlt_pkg::*;
#(
   parameter int BUCKET_COUNT = DEF_BUCKET_COUNT,
   parameter int ROW_W        = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [KEY_W-1:0]  key,
   output      logic              done,
   output      logic [ROW_W-1:0]  row
);

   localparam bit IS_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;

   generate
      if (IS_POW2) begin : g_mask
         // remainder is the low bits, available at once
         logic [KEY_W-1:0] masked;
         assign masked = key & KEY_W'(BUCKET_COUNT - 1);
         assign row    = masked[ROW_W-1:0];
         assign done   = start;
      end else begin : g_recip
         // quotient estimate from a 32-bit reciprocal is exact or one short,
         // so the remainder needs at most one correcting subtract
         localparam int QUO_SHIFT = KEY_W - 1 + $clog2(BUCKET_COUNT);
         localparam logic [KEY_W-1:0] RECIP =
            KEY_W'((64'd1 << QUO_SHIFT) / 64'(BUCKET_COUNT));
         localparam logic [ROW_W:0] DIVISOR = (ROW_W+1)'(BUCKET_COUNT);

         logic [KEY_W-1:0]   key_ff, key_in;
         logic [2*KEY_W-1:0] prod_ff, prod_in;
         logic [ROW_W:0]     rem_ff, rem_in;
         logic               key_vld_ff, prod_vld_ff, done_ff;
         logic [KEY_W-1:0]   quo, back;

         // key capture, reciprocal product, then remainder estimate
         always_comb begin
            key_in  = start ? key : key_ff;
            prod_in = (2*KEY_W)'(key_ff) * (2*KEY_W)'(RECIP);
            quo     = KEY_W'(prod_ff >> QUO_SHIFT);
            back    = quo * KEY_W'(BUCKET_COUNT);
            rem_in  = (ROW_W+1)'(key_ff - back);
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               key_vld_ff  <= 1'b0;
               prod_vld_ff <= 1'b0;
               done_ff     <= 1'b0;
            end else begin
               key_vld_ff  <= start;
               prod_vld_ff <= key_vld_ff;
               done_ff     <= prod_vld_ff;
               key_ff      <= key_in;
               prod_ff     <= prod_in;
               rem_ff      <= rem_in;
            end
         end

         // final correction of the estimate
         assign done = done_ff;
         assign row  = (rem_ff >= DIVISOR) ? ROW_W'(rem_ff - DIVISOR) : rem_ff[ROW_W-1:0];
      end
   endgenerate

endmodule

`default_nettype wire

### design/rlt_update.sv
// compares the ways of one bucket row and builds the written-back row and the result
// uses rlt_pkg types and codes
`default_nettype none

module rlt_update
   import rlt_pkg::*;
#(
   parameter int BUCKET_COUNT    = DEF_BUCKET_COUNT,
   parameter int WAYS_PER_BUCKET = DEF_WAYS_PER_BUCKET,
   parameter int ROW_W           = 8,
   parameter int WAY_W           = 2
) (
   input  wire cmd_type                              cmd,
   input  wire logic [ROW_W-1:0]                     row_addr,
   input  wire entry_type [WAYS_PER_BUCKET-1:0]      rd_row,
   output      logic                                 wr_en,
   output      entry_type [WAYS_PER_BUCKET-1:0]      wr_row,
   output      result_type                           result
);

   localparam int TABLE_SLOTS = BUCKET_COUNT * WAYS_PER_BUCKET;
   localparam int SLOT_RAW    = $clog2(TABLE_SLOTS) + 1;
   localparam int SLOT_W      = (SLOT_RAW > HANDLE_W + 1) ? SLOT_RAW : HANDLE_W + 1;

   logic [SLOT_W-1:0]          base;
   logic [SLOT_W-1:0]          way_full;
   logic [SLOT_W-1:0]          slot;
   logic [WAY_W-1:0]           way_h;
   logic [WAYS_PER_BUCKET-1:0] usable, hit, open;
   logic                       hit_any, open_any, handle_ok;
   logic [WAY_W-1:0]           hit_way, open_way, sel_way;
   entry_type                  cur, nxt;
   op_type                     op;

   // per-way match and free flags
   always_comb begin
      base     = SLOT_W'(row_addr) * SLOT_W'(WAYS_PER_BUCKET);
      way_full = SLOT_W'(cmd.handle) - base;
      way_h    = way_full[WAY_W-1:0];
      hit_any  = 1'b0;
      open_any = 1'b0;
      hit_way  = '0;
      open_way = '0;
      for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
         usable[w] = (base + SLOT_W'(w)) < SLOT_W'(STORE_DEPTH);
         hit[w]    = usable[w] && rd_row[w].valid && (rd_row[w].key == cmd.key);
         open[w]   = usable[w] && !rd_row[w].valid;
      end
      // lowest way wins
      for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
         if (hit[w]) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (open[w]) begin
            open_any = 1'b1;
            open_way = WAY_W'(w);
         end
      end
      handle_ok = (SLOT_W'(cmd.handle) < SLOT_W'(TABLE_SLOTS)) && rd_row[way_h].valid;
   end

   // operation decode and entry update
   always_comb begin
      op            = op_type'(cmd.op);
      sel_way       = way_h;
      wr_en         = 1'b0;
      result.handle = '0;
      result.length = '0;
      result.count  = '0;
      result.status = ST_OK;
      cur           = rd_row[way_h];
      nxt           = cur;
      slot          = SLOT_W'(cmd.handle);
      case (op)
         OP_ACQUIRE: begin
            if (hit_any) begin
               sel_way = hit_way;
               cur     = rd_row[hit_way];
               nxt     = cur;
               if (cur.count == COUNT_MAX) begin
                  result.status = ST_SATURATED;
               end else begin
                  nxt.count = cur.count + 1'b1;
                  wr_en     = 1'b1;
               end
            end else if (open_any) begin
               sel_way    = open_way;
               nxt.valid  = 1'b1;
               nxt.key    = cmd.key;
               nxt.count  = COUNT_W'(1);
               nxt.length = '0;
               wr_en      = 1'b1;
            end else begin
               result.status = ST_FULL;
            end
            slot = base + SLOT_W'(sel_way);
         end
         OP_RELEASE: begin
            if (!handle_ok) begin
               result.status = ST_NO_HANDLE;
            end else begin
               nxt.count = cur.count - 1'b1;
               nxt.valid = (nxt.count != '0);
               wr_en     = 1'b1;
            end
         end
         OP_GET: begin
            if (!handle_ok) begin
               result.status = ST_NO_HANDLE;
            end
         end
         OP_SET: begin
            if (!handle_ok) begin
               result.status = ST_NO_HANDLE;
            end else begin
               nxt.length = cmd.length;
               wr_en      = 1'b1;
            end
         end
         OP_UPDATE: begin
            if (!hit_any) begin
               result.status = ST_NO_KEY;
            end else begin
               sel_way    = hit_way;
               cur        = rd_row[hit_way];
               nxt        = cur;
               nxt.length = cmd.length;
               wr_en      = 1'b1;
            end
            slot = base + SLOT_W'(sel_way);
         end
         default: begin
            result.status = ST_OK;
         end
      endcase

      // entry fields go out only for successful or saturated lookups
      if ((result.status == ST_OK || result.status == ST_SATURATED) &&
          (op == OP_ACQUIRE || op == OP_RELEASE || op == OP_GET ||
           op == OP_SET || op == OP_UPDATE)) begin
         result.handle = slot[HANDLE_W-1:0];
         result.length = nxt.length;
         result.count  = nxt.valid ? nxt.count : '0;
      end
   end

   // written-back row: only the selected way changes
   always_comb begin
      wr_row = rd_row;
      for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
         if (WAY_W'(w) == sel_way) begin
            wr_row[w] = nxt;
         end
      end
   end

endmodule

`default_nettype wire

### design/refcounted_length_table.sv
// Refcounted length table top level: request/response streams, control sequencer
// Depends on rlt_pkg, rlt_store, rlt_keymod and rlt_update.
//
// Usage:
//   req channel: tuser carries the operation, tdata the key, handle and new length.
//   rsp channel: tuser carries the status, tdata the handle, length and count.
//   One response beat per request beat, in request order.
//   An item is read from the bucket row memory in its accept cycle and written
//   back in the next cycle, where its response is loaded into the output
//   register, when BUCKET_COUNT is a power of two, and for handle operations
//   always; a busy output register holds it in execute. Otherwise acquire and
//   update first reduce the key by a registered reciprocal multiply, and the
//   row is read when that completes. One item is in work at a time.
//   Reset starts a clearing pass over the rows, with req_tready low. A stalled
//   rsp_tready holds the response in the output register; the next request is
//   still accepted and its result waits in the sequencer until the output
//   register frees up.
`default_nettype none

module refcounted_length_table
   import rlt_pkg::*;
#(
   parameter int BUCKET_COUNT    = DEF_BUCKET_COUNT,
   parameter int WAYS_PER_BUCKET = DEF_WAYS_PER_BUCKET
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire logic [111:0] req_tdata,  // file_key[31:0], handle[41:32], new_length[105:42]
   input  wire logic [2:0]   req_tuser,  // operation[2:0]
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   output      logic [111:0] rsp_tdata,  // result_handle[9:0], result_length[73:10],
                                          // result_count[105:74]
   output      logic [2:0]   rsp_tuser   // status[2:0]
);

   localparam int ROW_W       = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int WAY_W       = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
   localparam int ROW_BITS    = ENTRY_W * WAYS_PER_BUCKET;
   localparam int RECIP_SHIFT = 24;
   localparam int PROD_W      = RECIP_SHIFT + HANDLE_W + 1;
   localparam logic [RECIP_SHIFT:0] RECIP =
      (RECIP_SHIFT+1)'(((1 << RECIP_SHIFT) + WAYS_PER_BUCKET - 1) / WAYS_PER_BUCKET);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_MOD,
      S_EXEC
   } state_type;

   state_type              state_ff, state_in;
   logic [ROW_W-1:0]       clr_ff, clr_in;
   cmd_type                cmd_ff, cmd_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;

   cmd_type                req_cmd;
   op_type                 req_op;
   logic                   accept, key_op;
   logic [PROD_W-1:0]      prod;
   logic [HANDLE_W-1:0]    quot;
   logic                   km_start, km_done;
   logic [ROW_W-1:0]       km_row;
   logic                   rd_en, wr_en, mem_wr_en;
   logic [ROW_W-1:0]       rd_addr, wr_addr;
   logic [ROW_BITS-1:0]    rd_data, wr_data;
   entry_type [WAYS_PER_BUCKET-1:0] rd_row, upd_row;
   result_type             upd_result;
   logic                   out_free;

   // request beat unpacking
   assign req_cmd.op     = req_tuser;
   assign req_cmd.key    = req_tdata[31:0];
   assign req_cmd.handle = req_tdata[41:32];
   assign req_cmd.length = req_tdata[105:42];
   assign req_op         = op_type'(req_tuser);
   assign key_op         = (req_op == OP_ACQUIRE) || (req_op == OP_UPDATE);

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign km_start   = accept && key_op;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // handle to bucket row by reciprocal multiply
   assign prod = PROD_W'(req_cmd.handle) * PROD_W'(RECIP);
   assign quot = prod[RECIP_SHIFT +: HANDLE_W];

   rlt_keymod #(
      .BUCKET_COUNT (BUCKET_COUNT),
      .ROW_W        (ROW_W)
   ) u_keymod (
      .clock (clock),
      .reset (reset),
      .start (km_start),
      .key   (req_cmd.key),
      .done  (km_done),
      .row   (km_row)
   );

   // row read issue
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = km_row;
      if (accept && !key_op) begin
         rd_en   = 1'b1;
         rd_addr = ROW_W'(quot);
      end else if ((accept || state_ff == S_MOD) && km_done) begin
         rd_en   = 1'b1;
         rd_addr = km_row;
      end
   end

   assign rd_row = rd_data;

   rlt_update #(
      .BUCKET_COUNT    (BUCKET_COUNT),
      .WAYS_PER_BUCKET (WAYS_PER_BUCKET),
      .ROW_W           (ROW_W),
      .WAY_W           (WAY_W)
   ) u_update (
      .cmd      (cmd_ff),
      .row_addr (row_ff),
      .rd_row   (rd_row),
      .wr_en    (wr_en),
      .wr_row   (upd_row),
      .result   (upd_result)
   );

   // write port: clearing pass or write-back
   always_comb begin
      if (state_ff == S_CLEAR) begin
         mem_wr_en = 1'b1;
         wr_addr   = clr_ff;
         wr_data   = '0;
      end else begin
         mem_wr_en = (state_ff == S_EXEC) && out_free && wr_en;
         wr_addr   = row_ff;
         wr_data   = upd_row;
      end
   end

   rlt_store #(
      .ROWS     (BUCKET_COUNT),
      .ADDR_W   (ROW_W),
      .ROW_BITS (ROW_BITS)
   ) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      row_in       = rd_en ? rd_addr : row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ROW_W'(BUCKET_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               state_in = rd_en ? S_EXEC : S_MOD;
            end
         end
         S_MOD: begin
            if (km_done) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = upd_result;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
         row_ff       <= row_in;
         rsp_ff       <= rsp_in;
      end
   end

   // response beat packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.count, rsp_ff.length, rsp_ff.handle};
   assign rsp_tuser  = rsp_ff.status;

`ifndef SYNTHESIS
   // no request is taken while the clearing pass starts
   a_clear_blocks: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("request accepted during clearing pass");

   // an item entering execute has had its row read
   a_read_before_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && $past(state_ff) != S_EXEC) |-> $past(rd_en))
      else $error("execute without row read");

   // one item in work at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second item accepted while one is in work");

   // remainder unit reports only while an item waits for it
   a_keymod_done: assert property (@(posedge clock) disable iff (reset)
      km_done |-> (state_ff == S_MOD || accept))
      else $error("stray bucket index completion");

   // write-back only from execute or clearing
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == S_CLEAR || state_ff == S_EXEC))
      else $error("row write outside execute");
`endif

endmodule

`default_nettype wire

### tb/sv/refcounted_length_table_tb.sv
`timescale 1ns / 100ps
// testbench for refcounted_length_table: streams table operations and checks every response
// against an in-bench table predictor; depends on rlt_pkg and the refcounted_length_table rtl

module refcounted_length_table_tb;
   import rlt_pkg::*;

   localparam int BUCKETS     = DEF_BUCKET_COUNT;
   localparam int WAYS        = DEF_WAYS_PER_BUCKET;
   localparam int SLOTS       = BUCKETS * WAYS;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 10;
   localparam int RANDOM_OPS  = 650;
   localparam int REPORT_MAX  = 10;

   // codes above OP_UPDATE are not operations; the block answers them with an empty ok
   localparam logic [OP_W-1:0] OP_CODE_TOP = 3'd7;
   // crowded buckets for the random part, one byte each
   localparam logic [31:0] POOL_BUCKETS = {8'd255, 8'd128, 8'd1, 8'd0};
   localparam logic [LENGTH_W-1:0] LENGTH_ALL_ONES = '1;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
      logic [LENGTH_W-1:0] length;
   } table_request_t;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [LENGTH_W-1:0] length;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } table_reply_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;  // file_key[31:0], handle[41:32], new_length[105:42]
   logic [2:0]   req_tuser = '0;  // operation[2:0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;       // result_handle[9:0], result_length[73:10], result_count[105:74]
   logic [2:0]   rsp_tuser;       // status[2:0]

   // shadow copy of the table
   bit                  shadow_valid [SLOTS];
   logic [KEY_W-1:0]    shadow_key   [SLOTS];
   logic [COUNT_W-1:0]  shadow_count [SLOTS];
   logic [LENGTH_W-1:0] shadow_length[SLOTS];

   table_request_t pending_requests[$];
   table_reply_t   expected_replies[$];
   table_request_t driven_request;
   int             total_requests = 1;
   int             accepted_count = 0;
   int             reply_count = 0;
   int             mismatch_count = 0;
   int             cycle_count = 0;

   refcounted_length_table #(
      .BUCKET_COUNT(BUCKETS),
      .WAYS_PER_BUCKET(WAYS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // report of the entry in a slot, count 0 once freed
   function automatic table_reply_t slot_reply(int unsigned slot, logic [STATUS_W-1:0] status);
      table_reply_t r;
      r.handle = slot[HANDLE_W-1:0];
      r.length = shadow_length[slot];
      r.count  = shadow_valid[slot] ? shadow_count[slot] : '0;
      r.status = status;
      return r;
   endfunction

   // applies one operation to the shadow table and returns the response it should give
   function automatic table_reply_t apply_operation(table_request_t q);
      table_reply_t r;
      logic [31:0]  bucket;
      int unsigned  base;
      int unsigned  slot;
      int           w;
      bit           hit;
      bit           handle_live;
      r = '0;
      r.status = ST_OK;
      bucket = q.key % BUCKETS;
      base = bucket * WAYS;
      hit = 0;
      slot = 0;
      for (w = 0; w < WAYS; w++) begin
         if (!hit && shadow_valid[base + w] && shadow_key[base + w] == q.key) begin
            hit = 1;
            slot = base + w;
         end
      end
      handle_live = (q.handle < SLOTS) && shadow_valid[q.handle];
      case (q.op)
         OP_ACQUIRE: begin
            if (hit) begin
               // count is only reachable at its ceiling after 2^32-1 acquires
               if (shadow_count[slot] == COUNT_MAX) begin
                  r = slot_reply(slot, ST_SATURATED);
               end else begin
                  shadow_count[slot] = shadow_count[slot] + 1;
                  r = slot_reply(slot, ST_OK);
               end
            end else begin
               r.status = ST_FULL;
               for (w = 0; w < WAYS; w++) begin
                  if (r.status == ST_FULL && !shadow_valid[base + w]) begin
                     slot = base + w;
                     shadow_valid[slot]  = 1;
                     shadow_key[slot]    = q.key;
                     shadow_count[slot]  = 1;
                     shadow_length[slot] = '0;
                     r = slot_reply(slot, ST_OK);
                  end
               end
            end
         end
         OP_RELEASE: begin
            if (!handle_live) begin
               r.status = ST_NO_HANDLE;
            end else begin
               shadow_count[q.handle] = shadow_count[q.handle] - 1;
               if (shadow_count[q.handle] == 0) shadow_valid[q.handle] = 0;
               r = slot_reply(q.handle, ST_OK);
            end
         end
         OP_GET: begin
            if (!handle_live) r.status = ST_NO_HANDLE;
            else r = slot_reply(q.handle, ST_OK);
         end
         OP_SET: begin
            if (!handle_live) begin
               r.status = ST_NO_HANDLE;
            end else begin
               shadow_length[q.handle] = q.length;
               r = slot_reply(q.handle, ST_OK);
            end
         end
         OP_UPDATE: begin
            if (!hit) begin
               r.status = ST_NO_KEY;
            end else begin
               shadow_length[slot] = q.length;
               r = slot_reply(slot, ST_OK);
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // idle percentages per phase: sender-heavy, receiver-heavy, then none
   function automatic int idle_pct(bit for_sender);
      int phase;
      phase = accepted_count * 3 / total_requests;
      if (phase == 0) return for_sender ? 25 : 72;
      if (phase == 1) return for_sender ? 72 : 25;
      return 0;
   endfunction

   function automatic logic [31:0] pool_bucket();
      int i;
      i = $urandom_range(0, 3);
      return {24'd0, POOL_BUCKETS[8*i +: 8]};
   endfunction

   // keys that collide in a few buckets, so hits and full buckets are common
   function automatic logic [KEY_W-1:0] pool_key();
      logic [31:0] k;
      k = $urandom_range(0, 5);
      if (k == 5) k = 32'h00FF_FFFF;
      return k * BUCKETS + pool_bucket();
   endfunction

   function automatic logic [HANDLE_W-1:0] pool_handle();
      logic [31:0] h;
      h = pool_bucket() * WAYS + $urandom_range(0, WAYS - 1);
      return h[HANDLE_W-1:0];
   endfunction

   task automatic queue_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                logic [HANDLE_W-1:0] handle, logic [LENGTH_W-1:0] length);
      table_request_t q;
      q.op = op;
      q.key = key;
      q.handle = handle;
      q.length = length;
      pending_requests.push_back(q);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_replies.push_back(apply_operation(driven_request));
            accepted_count <= accepted_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(0, 99) >= idle_pct(1)) begin
               driven_request = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {6'd0, driven_request.length, driven_request.handle,
                              driven_request.key};
               req_tuser  <= driven_request.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      table_reply_t exp_r;
      table_reply_t got_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_r.handle = rsp_tdata[9:0];
            got_r.length = rsp_tdata[73:10];
            got_r.count  = rsp_tdata[105:74];
            got_r.status = rsp_tuser;
            if (expected_replies.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= REPORT_MAX)
                  $display("response beat %0d arrived with nothing expected", reply_count);
            end else begin
               exp_r = expected_replies.pop_front();
               if (got_r !== exp_r) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= REPORT_MAX)
                     $display({"response beat %0d: expected handle %0d length %h count %0d ",
                               "status %0d, got handle %0d length %h count %0d status %0d"},
                              reply_count, exp_r.handle, exp_r.length, exp_r.count,
                              exp_r.status, got_r.handle, got_r.length, got_r.count,
                              got_r.status);
               end
            end
            reply_count = reply_count + 1;
         end
         rsp_tready <= ($urandom_range(0, 99) >= idle_pct(0));
      end
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      int          n;
      int          pick;
      logic [OP_W-1:0]     op;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
      logic [LENGTH_W-1:0] length;

      // directed: empty table, extremes, a full bucket, free and reuse
      queue_request(OP_GET,     32'd0,         10'd0,    64'd0);
      queue_request(OP_RELEASE, 32'hFFFF_FFFF, 10'd1023, LENGTH_ALL_ONES);
      queue_request(OP_UPDATE,  32'hFFFF_FFFF, 10'd0,    LENGTH_ALL_ONES);
      queue_request(OP_ACQUIRE, 32'd0,         10'd1023, LENGTH_ALL_ONES);
      queue_request(OP_ACQUIRE, 32'd0,         10'd0,    64'd0);
      queue_request(OP_SET,     32'hFFFF_FFFF, 10'd0,    LENGTH_ALL_ONES);
      queue_request(OP_GET,     32'd0,         10'd0,    64'd0);
      queue_request(OP_UPDATE,  32'd0,         10'd1023, 64'd0);
      queue_request(OP_GET,     32'd0,         10'd0,    64'd0);
      queue_request(OP_ACQUIRE, 32'hFFFF_FFFF, 10'd0,    64'd0);
      queue_request(OP_ACQUIRE, 32'h00FF_FFFF, 10'd0,    64'd0);
      queue_request(OP_ACQUIRE, 32'h00FF_FEFF, 10'd0,    64'd0);
      queue_request(OP_ACQUIRE, 32'h00FF_FDFF, 10'd0,    64'd0);
      queue_request(OP_ACQUIRE, 32'h00FF_FCFF, 10'd0,    64'd0);
      queue_request(OP_SET,     32'd0,         10'd1023, LENGTH_ALL_ONES);
      queue_request(OP_GET,     32'd0,         10'd1023, 64'd0);
      queue_request(OP_RELEASE, 32'd0,         10'd1023, 64'd0);
      queue_request(OP_GET,     32'd0,         10'd1023, 64'd0);
      queue_request(OP_ACQUIRE, 32'h00FF_FCFF, 10'd0,    64'd0);
      queue_request(OP_GET,     32'd0,         10'd1023, 64'd0);
      queue_request(OP_RELEASE, 32'd0,         10'd0,    64'd0);
      queue_request(OP_RELEASE, 32'd0,         10'd0,    64'd0);
      queue_request(OP_GET,     32'd0,         10'd0,    64'd0);
      queue_request(OP_W'(OP_UPDATE + 1), 32'hFFFF_FFFF, 10'd1023, LENGTH_ALL_ONES);
      queue_request(OP_CODE_TOP,   32'hFFFF_FFFF, 10'd1020, LENGTH_ALL_ONES);

      // random: mostly crowded keys and live handles, some noise
      for (n = 0; n < RANDOM_OPS; n++) begin
         pick   = $urandom_range(0, 99);
         key    = ($urandom_range(0, 99) < 80) ? pool_key() : $urandom;
         handle = ($urandom_range(0, 99) < 85) ? pool_handle() :
                                                 HANDLE_W'($urandom_range(0, 1023));
         case ($urandom_range(0, 9))
            0:       length = '0;
            1:       length = LENGTH_ALL_ONES;
            default: length = {$urandom, $urandom};
         endcase
         if (pick < 35)      op = OP_ACQUIRE;
         else if (pick < 60) op = OP_RELEASE;
         else if (pick < 72) op = OP_GET;
         else if (pick < 82) op = OP_SET;
         else if (pick < 94) op = OP_UPDATE;
         else                op = OP_W'($urandom_range(OP_UPDATE + 1, OP_CODE_TOP));
         queue_request(op, key, handle, length);
      end
      total_requests = pending_requests.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // drain, then give the block time for any stray beat
      @(negedge clock);
      while (pending_requests.size() > 0 || req_tvalid || expected_replies.size() > 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### sim.f
design/rlt_pkg.sv
design/rlt_store.sv
design/rlt_keymod.sv
design/rlt_update.sv
design/refcounted_length_table.sv
tb/sv/refcounted_length_table_tb.sv
